[rtl/byte_ring_buffer_word_peek_assert.svh]
// assertion macros for the byte ring buffer with word peek
`ifndef BYTE_RING_BUFFER_WORD_PEEK_ASSERT_SVH
`define BYTE_RING_BUFFER_WORD_PEEK_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRBWP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("brbwp assertion failed");

// next-cycle implication, checked out of reset
`define BRBWP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("brbwp assertion failed");

`endif

[rtl/brbwp_pkg.sv]
// package with types and constants of the byte ring buffer with word peek
package brbwp_pkg;

    localparam int DEPTH = 4096;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int LANES = 4;
    localparam int LANE_W = $clog2(LANES);
    localparam int ROWS = DEPTH / LANES;
    localparam int ROW_W = PTR_W - LANE_W;

    localparam logic [1:0] MODE_APPEND  = 2'd0;
    localparam logic [1:0] MODE_CONSUME = 2'd1;
    localparam logic [1:0] MODE_PEEK    = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NOROOM = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  data_byte;
        logic [12:0] count;
        logic [11:0] offset;
    } t_in_item;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  status;
        logic [12:0] used_count;
        logic [12:0] free_count;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

[rtl/brbwp_ctrl.sv]
// controller: item sequencing and handshakes of both channels
module brbwp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output brbwp_pkg::t_dp_cmd o_cmd
);

    brbwp_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brbwp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            brbwp_pkg::S_IDLE: begin
                // no transfer is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = brbwp_pkg::S_EXEC;
                end
            end
            brbwp_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = brbwp_pkg::S_DONE;
            end
            brbwp_pkg::S_DONE: begin
                // wait until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = brbwp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = brbwp_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/brbwp_dp.sv]
// datapath: pointers, full flag, four byte banks and the result register
module brbwp_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  brbwp_pkg::t_dp_cmd   i_cmd,
    input  brbwp_pkg::t_in_item  i_item,
    output brbwp_pkg::t_out_item o_item
);

    localparam int PTR_W  = brbwp_pkg::PTR_W;
    localparam int CNT_W  = brbwp_pkg::CNT_W;
    localparam int LANES  = brbwp_pkg::LANES;
    localparam int LANE_W = brbwp_pkg::LANE_W;
    localparam int ROWS   = brbwp_pkg::ROWS;
    localparam int ROW_W  = brbwp_pkg::ROW_W;

    brbwp_pkg::t_in_item  r_item;
    brbwp_pkg::t_out_item r_out, n_out;

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic              r_full, n_full;
    logic [1:0]        r_status, n_status;
    logic              r_peek_ok, n_peek_ok;
    logic [LANE_W-1:0] r_lane;

    logic [CNT_W-1:0]  w_used;
    logic [PTR_W-1:0]  w_tail_inc;
    logic [PTR_W-1:0]  w_peek_addr;
    logic              w_wr_en;
    logic [7:0]        w_rd [LANES];
    logic [31:0]       w_word;

    assign w_used      = r_full ? CNT_W'(brbwp_pkg::DEPTH) : {1'b0, r_tail - r_head};
    assign w_tail_inc  = r_tail + PTR_W'(1);
    assign w_peek_addr = r_head + r_item.offset;

    // next pointers, flag and status of the item in execution
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_full    = r_full;
        n_status  = brbwp_pkg::STATUS_OK;
        n_peek_ok = 1'b0;
        w_wr_en   = 1'b0;
        unique case (r_item.mode)
            brbwp_pkg::MODE_APPEND: begin
                if (r_full) begin
                    n_status = brbwp_pkg::STATUS_NOROOM;
                end else begin
                    w_wr_en = 1'b1;
                    n_tail  = w_tail_inc;
                    if (w_tail_inc == r_head) begin
                        n_full = 1'b1;
                    end
                end
            end
            brbwp_pkg::MODE_CONSUME: begin
                if (r_item.count > w_used) begin
                    n_status = brbwp_pkg::STATUS_RANGE;
                end else if (r_item.count != '0) begin
                    n_head = r_head + r_item.count[PTR_W-1:0];
                    if (r_item.count == w_used) begin
                        n_full = 1'b0;
                    end
                end
            end
            brbwp_pkg::MODE_PEEK: begin
                if (({1'b0, r_item.offset} + CNT_W'(LANES)) > w_used) begin
                    n_status = brbwp_pkg::STATUS_RANGE;
                end else begin
                    n_peek_ok = 1'b1;
                end
            end
            default: begin
                n_status = brbwp_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_full <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_peek_ok <= n_peek_ok;
            r_lane    <= w_peek_addr[LANE_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    // one bank per byte lane, each bank reads the row its byte of the word sits in
    for (genvar b = 0; b < LANES; b++) begin : g_bank
        logic [7:0]        r_mem [ROWS];
        logic [7:0]        r_rd;
        logic [LANE_W-1:0] w_k;
        logic [PTR_W-1:0]  w_addr;
        logic [ROW_W-1:0]  w_row;

        assign w_k    = LANE_W'(b) - w_peek_addr[LANE_W-1:0];
        assign w_addr = w_peek_addr + PTR_W'(w_k);
        assign w_row  = w_addr[PTR_W-1:LANE_W];

        always_ff @(posedge i_clk) begin
            if (w_wr_en && i_cmd.exec && (r_tail[LANE_W-1:0] == LANE_W'(b))) begin
                r_mem[r_tail[PTR_W-1:LANE_W]] <= r_item.data_byte;
            end
            if (i_cmd.exec) begin
                r_rd <= r_mem[w_row];
            end
        end

        assign w_rd[b] = r_rd;
    end

    // first byte of the word comes from the lane of the peek address
    always_comb begin
        logic [LANE_W-1:0] lane;
        w_word = '0;
        for (int k = 0; k < LANES; k++) begin
            lane   = r_lane + LANE_W'(k);
            w_word = {w_word[23:0], w_rd[lane]};
        end
    end

    always_comb begin
        n_out.word       = r_peek_ok ? w_word : 32'd0;
        n_out.status     = r_status;
        n_out.used_count = w_used;
        n_out.free_count = CNT_W'(brbwp_pkg::DEPTH) - w_used;
    end

    assign o_item = r_out;

endmodule

[rtl/byte_ring_buffer_word_peek.sv]
// top level of the byte ring buffer with word peek
//
// Input channel i_in_valid / o_in_ready carries one item: append a byte at the
// tail, drop count bytes from the head, or peek a big-endian 32-bit word at
// offset bytes past the head (wrapping round the store). Output channel
// o_out_valid / i_out_ready returns exactly one result per item: the peeked
// word (zero unless a peek succeeded), a status (ok, no room, out of range)
// and the used and free byte counts after the item.
// An item passes through the transfer, the pointer update with the bank reads
// (one port per byte lane of four banks), and the load of the result register,
// which waits while the output register is full and not being taken. A new
// item is taken only once the result of the last one is loaded.
// The result sits in an output register, so a stalled receiver holds only the
// next item's final step until the register is taken.
// Synchronous active-low reset empties the buffer (both pointers zero, full
// flag clear), drops any pending result and holds o_in_ready low while
// asserted; store contents are not cleared.
module byte_ring_buffer_word_peek (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  brbwp_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output brbwp_pkg::t_out_item o_out_data
);

    `include "byte_ring_buffer_word_peek_assert.svh"

    brbwp_pkg::t_dp_cmd w_cmd;

    brbwp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    brbwp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_in_data),
        .o_item  (o_out_data)
    );

    `BRBWP_ASSERT_NOW(a_counts_sum, o_out_valid,
        ({1'b0, o_out_data.used_count} + {1'b0, o_out_data.free_count})
            == (brbwp_pkg::CNT_W + 1)'(brbwp_pkg::DEPTH))
    `BRBWP_ASSERT_NOW(a_word_zero_on_error,
        o_out_valid && (o_out_data.status != brbwp_pkg::STATUS_OK),
        o_out_data.word == 32'd0)
    `BRBWP_ASSERT_NOW(a_noroom_when_full,
        o_out_valid && (o_out_data.status == brbwp_pkg::STATUS_NOROOM),
        o_out_data.used_count == brbwp_pkg::CNT_W'(brbwp_pkg::DEPTH))
    `BRBWP_ASSERT_NEXT(a_one_item_in_flight, i_in_valid && o_in_ready, !o_in_ready)

endmodule

[tb/testbench.sv]
// self-checking testbench for the byte ring buffer with word peek
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1700;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    brbwp_pkg::t_in_item  in_data = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    brbwp_pkg::t_out_item o_out_data;

    byte_ring_buffer_word_peek dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 clk = ~clk;

    // mirror of the buffer state
    logic [7:0]  mirror_store [brbwp_pkg::DEPTH];
    logic [11:0] mirror_head = '0;
    logic [11:0] mirror_tail = '0;
    logic        mirror_full = 1'b0;

    brbwp_pkg::t_out_item pending_results [$];

    bit sender_idle = 1'b1;
    bit receiver_idle = 1'b1;
    int hold_request = 0;
    int errors = 0;
    int results_checked = 0;
    int items_sent = 0;
    int noroom_seen = 0;
    int range_seen = 0;

    function automatic logic [12:0] ring_used();
        if (mirror_full) return 13'(brbwp_pkg::DEPTH);
        return {1'b0, 12'(mirror_tail - mirror_head)};
    endfunction

    // applies one item to the mirror and returns the result it must give
    function automatic brbwp_pkg::t_out_item ring_apply(input brbwp_pkg::t_in_item it);
        brbwp_pkg::t_out_item r;
        logic [12:0]          used;
        logic [11:0]          idx;
        r = '0;
        used = ring_used();
        case (it.mode)
            brbwp_pkg::MODE_APPEND: begin
                if (mirror_full) begin
                    r.status = brbwp_pkg::STATUS_NOROOM;
                end else begin
                    mirror_store[mirror_tail] = it.data_byte;
                    mirror_tail = mirror_tail + 12'd1;
                    if (mirror_tail == mirror_head) mirror_full = 1'b1;
                end
            end
            brbwp_pkg::MODE_CONSUME: begin
                if (it.count > used) begin
                    r.status = brbwp_pkg::STATUS_RANGE;
                end else if (it.count != 13'd0) begin
                    // count of a full store wraps the head onto itself
                    mirror_head = mirror_head + it.count[11:0];
                    if (it.count == used) mirror_full = 1'b0;
                end
            end
            brbwp_pkg::MODE_PEEK: begin
                if (int'(it.offset) + 4 > int'(used)) begin
                    r.status = brbwp_pkg::STATUS_RANGE;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        idx = mirror_head + it.offset + 12'(i);
                        r.word = {r.word[23:0], mirror_store[idx]};
                    end
                end
            end
            default: ;
        endcase
        used = ring_used();
        r.used_count = used;
        r.free_count = 13'(brbwp_pkg::DEPTH) - used;
        return r;
    endfunction

    function automatic brbwp_pkg::t_in_item rand_item(input logic [1:0] mode);
        brbwp_pkg::t_in_item it;
        it.mode = mode;
        it.data_byte = 8'($urandom);
        it.count = 13'($urandom);
        it.offset = 12'($urandom);
        return it;
    endfunction

    task automatic send_item(input brbwp_pkg::t_in_item it);
        int gap;
        gap = sender_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!o_in_ready);
        pending_results.push_back(ring_apply(it));
        items_sent++;
    endtask

    // value goes to the field that the mode uses, the rest stays random
    task automatic send_op(input logic [1:0] mode, input int unsigned value);
        brbwp_pkg::t_in_item it;
        it = rand_item(mode);
        case (mode)
            brbwp_pkg::MODE_APPEND:  it.data_byte = value[7:0];
            brbwp_pkg::MODE_CONSUME: it.count = value[12:0];
            brbwp_pkg::MODE_PEEK:    it.offset = value[11:0];
            default: ;
        endcase
        send_item(it);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // result side: random stalls, long hold on request, field compare
    initial begin
        int                   gap;
        brbwp_pkg::t_out_item want;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request > 0) begin
                gap = hold_request;
                hold_request = 0;
            end else begin
                gap = receiver_idle ? $urandom_range(0, 15) : 0;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(o_out_valid && out_ready));
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", o_out_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.status == brbwp_pkg::STATUS_NOROOM) noroom_seen++;
                if (want.status == brbwp_pkg::STATUS_RANGE) range_seen++;
                if (o_out_data.word !== want.word) begin
                    $error("word: expected %h, got %h", want.word, o_out_data.word);
                    errors++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.used_count !== want.used_count) begin
                    $error("used_count: expected %0d, got %0d",
                           want.used_count, o_out_data.used_count);
                    errors++;
                end
                if (o_out_data.free_count !== want.free_count) begin
                    $error("free_count: expected %0d, got %0d",
                           want.free_count, o_out_data.free_count);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_and_small();
        send_op(brbwp_pkg::MODE_CONSUME, 0);
        send_op(brbwp_pkg::MODE_CONSUME, 1);
        send_op(brbwp_pkg::MODE_CONSUME, 8191);
        send_op(brbwp_pkg::MODE_PEEK, 0);
        send_op(brbwp_pkg::MODE_PEEK, 4095);
        send_item('1);
        send_op(brbwp_pkg::MODE_APPEND, 8'h00);
        send_op(brbwp_pkg::MODE_APPEND, 8'hFF);
        send_op(brbwp_pkg::MODE_APPEND, 8'hA5);
        send_op(brbwp_pkg::MODE_APPEND, 8'h5A);
        send_op(brbwp_pkg::MODE_PEEK, 0);
        send_op(brbwp_pkg::MODE_PEEK, 1);
        send_op(brbwp_pkg::MODE_CONSUME, 0);
        send_op(brbwp_pkg::MODE_CONSUME, 5);
        send_op(brbwp_pkg::MODE_CONSUME, 2);
        send_op(brbwp_pkg::MODE_PEEK, 0);
        send_op(brbwp_pkg::MODE_APPEND, 8'h3C);
        send_op(brbwp_pkg::MODE_APPEND, 8'hC3);
        send_op(brbwp_pkg::MODE_PEEK, 0);
        send_op(brbwp_pkg::MODE_CONSUME, 4);
        send_item(rand_item(MODE_UNUSED));
        settle();
    endtask

    task automatic test_fill_and_wrap();
        int n;
        // back-to-back stretch with no idling on either side
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        while (!mirror_full) send_op(brbwp_pkg::MODE_APPEND, $urandom);
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        send_op(brbwp_pkg::MODE_APPEND, $urandom);
        send_op(brbwp_pkg::MODE_APPEND, $urandom);
        send_op(brbwp_pkg::MODE_PEEK, 4092);
        send_op(brbwp_pkg::MODE_PEEK, 4093);
        send_op(brbwp_pkg::MODE_PEEK, 32'(12'(12'd4094 - mirror_head)));
        send_op(brbwp_pkg::MODE_PEEK, 4095);
        send_op(brbwp_pkg::MODE_CONSUME, 4097);
        send_op(brbwp_pkg::MODE_CONSUME, 8191);
        send_op(brbwp_pkg::MODE_CONSUME, 4096);
        send_op(brbwp_pkg::MODE_PEEK, 0);
        send_op(brbwp_pkg::MODE_APPEND, $urandom);
        send_op(brbwp_pkg::MODE_CONSUME, 1);
        // refill deep so later peeks reach far offsets across the wrap
        n = 2800;
        repeat (n) send_op(brbwp_pkg::MODE_APPEND, $urandom);
        send_op(brbwp_pkg::MODE_PEEK, 32'(ring_used()) - 4);
        settle();
    endtask

    task automatic test_output_stall();
        sender_idle = 1'b0;
        hold_request = 400;
        repeat (40) begin
            if ($urandom_range(0, 1) == 0) send_op(brbwp_pkg::MODE_APPEND, $urandom);
            else send_op(brbwp_pkg::MODE_PEEK, $urandom_range(0, 32'(ring_used()) - 4));
        end
        sender_idle = 1'b1;
        settle();
    endtask

    task automatic test_random_traffic();
        int unsigned goal, used, pick, r, cap, app_w, con_w;
        int          counted;
        counted = 0;
        goal = 2000;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 149) == 0) begin
                r = $urandom_range(0, 3);
                goal = (r == 0) ? 0 : (r == 1) ? brbwp_pkg::DEPTH
                                               : $urandom_range(0, brbwp_pkg::DEPTH);
            end
            // runs with both sides busy now and then
            if ($urandom_range(0, 99) == 0) begin
                sender_idle = ~sender_idle;
                receiver_idle = ~receiver_idle;
            end
            used = 32'(ring_used());
            app_w = (used < goal) ? 55 : 20;
            con_w = (used < goal) ? 4 : 25;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_item(rand_item(MODE_UNUSED));
            end else if (pick < 8) begin
                send_item(rand_item(2'($urandom)));
                counted++;
            end else if (pick < 8 + app_w) begin
                send_op(brbwp_pkg::MODE_APPEND, $urandom);
                counted++;
            end else if (pick < 8 + app_w + con_w) begin
                r = $urandom_range(0, 9);
                cap = (used < 16) ? used : 16;
                if (r < 7) send_op(brbwp_pkg::MODE_CONSUME, $urandom_range(0, cap));
                else if (r == 7) send_op(brbwp_pkg::MODE_CONSUME, used);
                else if (r == 8) send_op(brbwp_pkg::MODE_CONSUME, used + 1);
                else send_op(brbwp_pkg::MODE_CONSUME, $urandom);
                counted++;
            end else begin
                r = $urandom_range(0, 9);
                if (used >= 4 && r < 7) begin
                    send_op(brbwp_pkg::MODE_PEEK, $urandom_range(0, used - 4));
                end else if (r < 9) begin
                    send_op(brbwp_pkg::MODE_PEEK, (used >= 3) ? used - 3 : 0);
                end else begin
                    send_op(brbwp_pkg::MODE_PEEK, $urandom);
                end
                counted++;
            end
        end
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        settle();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_and_small();
        test_fill_and_wrap();
        test_output_stall();
        test_random_traffic();
        $display("checked %0d results from %0d items of every mode, unused one included",
                 results_checked, items_sent);
        $display("saw %0d rejected writes and %0d range errors, full store, wrapped peeks",
                 noroom_seen, range_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(6_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
